// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the comment stripper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/cscw_pkg.sv -----
// ----------------------------------------------------------------------------
// cscw_pkg
// Types and character constants shared by the comment stripper modules.
// ----------------------------------------------------------------------------
package cscw_pkg;

	localparam int MAX_RESULTS = 3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_SLASH  = 3'd1,
		MODE_LINE   = 3'd2,
		MODE_BLOCK  = 3'd3,
		MODE_STAR   = 3'd4,
		MODE_STRING = 3'd5
	} scan_mode_t;

	// Up to three results caused by one input byte.
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] chars;
		logic [1:0]                  num;
		logic                        term;
		logic [15:0]                 length;
	} burst_t;

endpackage

// ----- rtl/cscw_scan.sv -----
// ----------------------------------------------------------------------------
// cscw_scan
// Scanner state and the single-pass decode of one byte into its results.
// ----------------------------------------------------------------------------
module cscw_scan #(
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          char_s1,
	output cscw_pkg::burst_t    burst
);
	import cscw_pkg::*;

	scan_mode_t            mode_q, mode_d;
	logic                  pend_nl_q, pend_nl_d;
	logic                  pend_sp_q, pend_sp_d;
	logic [COUNT_BITS-1:0] count_q, count_d, count_sat;
	logic [COUNT_BITS:0]   count_sum;
	logic                  emit_sep, emit_slash, emit_c, term;
	logic                  has_sep, is_nl, is_sp, is_quote;
	logic [7:0]            sep_ch;
	logic [1:0]            byte_cnt;

	assign has_sep  = pend_nl_q | pend_sp_q;
	assign sep_ch   = pend_nl_q ? CH_LF : CH_SPACE;
	assign is_nl    = (char_s1 == CH_LF) || (char_s1 == CH_CR);
	assign is_sp    = (char_s1 == CH_SPACE) || (char_s1 == CH_TAB);
	assign is_quote = (char_s1 == CH_QUOTE);

	always_comb begin
		emit_sep   = 1'b0;
		emit_slash = 1'b0;
		emit_c     = 1'b0;
		term       = 1'b0;
		mode_d     = mode_q;
		pend_nl_d  = pend_nl_q;
		pend_sp_d  = pend_sp_q;
		if (char_s1 == CH_NUL) begin
			if (mode_q == MODE_SLASH) begin
				emit_sep   = has_sep;
				emit_slash = 1'b1;
			end
			term      = 1'b1;
			mode_d    = MODE_NORMAL;
			pend_nl_d = 1'b0;
			pend_sp_d = 1'b0;
		end else begin
			case (mode_q)
				MODE_SLASH: begin
					if (char_s1 == CH_SLASH) begin
						mode_d = MODE_LINE;
					end else if (char_s1 == CH_STAR) begin
						mode_d = MODE_STAR;
					end else begin
						emit_sep   = has_sep;
						emit_slash = 1'b1;
						pend_nl_d  = 1'b0;
						pend_sp_d  = 1'b0;
						mode_d     = MODE_NORMAL;
						if (is_nl) begin
							pend_nl_d = 1'b1;
						end else if (is_sp) begin
							pend_sp_d = 1'b1;
						end else begin
							emit_c = 1'b1;
							mode_d = is_quote ? MODE_STRING : MODE_NORMAL;
						end
					end
				end
				MODE_LINE: begin
					if (char_s1 == CH_LF) begin
						mode_d    = MODE_NORMAL;
						pend_nl_d = 1'b1;
					end
				end
				MODE_BLOCK: begin
					if (char_s1 == CH_STAR)
						mode_d = MODE_STAR;
				end
				MODE_STAR: begin
					if (char_s1 == CH_SLASH)
						mode_d = MODE_NORMAL;
					else if (char_s1 != CH_STAR)
						mode_d = MODE_BLOCK;
				end
				MODE_STRING: begin
					emit_c = 1'b1;
					if (is_quote)
						mode_d = MODE_NORMAL;
				end
				default: begin
					mode_d = MODE_NORMAL;
					if (char_s1 == CH_SLASH) begin
						mode_d = MODE_SLASH;
					end else if (is_nl) begin
						pend_nl_d = 1'b1;
					end else if (is_sp) begin
						pend_sp_d = 1'b1;
					end else begin
						emit_sep  = has_sep;
						pend_nl_d = 1'b0;
						pend_sp_d = 1'b0;
						emit_c    = 1'b1;
						mode_d    = is_quote ? MODE_STRING : MODE_NORMAL;
					end
				end
			endcase
		end
	end

	assign byte_cnt  = 2'(emit_sep) + 2'(emit_slash) + 2'(emit_c);
	assign count_sum = {1'b0, count_q} + (COUNT_BITS+1)'(byte_cnt);
	assign count_sat = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];
	assign count_d   = term ? '0 : count_sat;

	always_comb begin
		logic [1:0] n;
		n            = 2'd0;
		burst.chars  = '0;
		burst.term   = term;
		burst.length = '0;
		if (emit_sep) begin
			burst.chars[n] = sep_ch;
			n              = n + 2'd1;
		end
		if (emit_slash) begin
			burst.chars[n] = CH_SLASH;
			n              = n + 2'd1;
		end
		if (emit_c) begin
			burst.chars[n] = char_s1;
			n              = n + 2'd1;
		end
		if (term) begin
			burst.chars[n] = CH_NUL;
			n              = n + 2'd1;
			if (count_sat > COUNT_BITS'(16'hFFFF))
				burst.length = 16'hFFFF;
			else
				burst.length = 16'(count_sat);
		end
		burst.num = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			pend_nl_q <= 1'b0;
			pend_sp_q <= 1'b0;
			count_q   <= '0;
		end else if (step) begin
			mode_q    <= mode_d;
			pend_nl_q <= pend_nl_d;
			pend_sp_q <= pend_sp_d;
			count_q   <= count_d;
		end
	end

endmodule

// ----- rtl/cscw_emit.sv -----
// ----------------------------------------------------------------------------
// cscw_emit
// Result register that holds one burst and hands it out one result a cycle while out_stall is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cscw_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  cscw_pkg::burst_t burst,
	output logic             free,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_char,
	output logic [15:0]      out_length,
	output logic             is_end,
	output logic             last
);
	import cscw_pkg::*;

	burst_t     burst_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       final_res;
	logic       take;

	assign final_res  = (idx_q == burst_q.num - 2'd1);
	assign take       = busy_q && !out_stall;
	assign free       = !busy_q || (take && final_res);

	assign out_valid  = busy_q;
	assign out_char   = burst_q.chars[idx_q];
	assign last       = final_res;
	assign is_end     = burst_q.term && final_res;
	assign out_length = is_end ? burst_q.length : 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (take) begin
			if (final_res)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			burst_q <= burst;
	end

	`ASSERT_CLK(a_num_nonzero, clk, arst_n, !(busy_q && (burst_q.num == 2'd0)), "empty burst held")
	`ASSERT_CLK(a_idx_range, clk, arst_n, !busy_q || (idx_q < burst_q.num), "index past burst")
	`ASSERT_CLK(a_load_free, clk, arst_n, !load || free, "burst loaded over pending results")
	`ASSERT_CLK(a_len_only_end, clk, arst_n, (out_length == 16'd0) || is_end, "length off terminator")

endmodule

// ----- rtl/comment_strip_whitespace_collapse.sv -----
// ----------------------------------------------------------------------------
// comment_strip_whitespace_collapse
// Strips comments and collapses whitespace from a byte stream.
// ----------------------------------------------------------------------------
// Input channel: in_char with in_valid/in_stall; a transaction completes on a
// rising edge with in_valid high and in_stall low. A zero byte ends a text.
// Output channel: out_char, out_length, is_end and last with out_valid and
// out_stall. Each input byte causes zero to three results; last marks the
// final one, and the terminator carries is_end and the saturated length.
// The input byte is registered, decoded in one pass and its results loaded
// into a result register once that register is free; the first result is
// offered from there. One byte is taken per cycle while each byte yields at
// most one result and the receiver does not stall; a byte with two or three
// results holds the result register until all are taken, which stalls a
// following byte that has results.
// Bytes that yield no result pass even while the receiver stalls.
// Reset returns the scanner to normal text mode with no pending separator,
// a zero length count and both registers empty.
// ----------------------------------------------------------------------------
module comment_strip_whitespace_collapse #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic [15:0] out_length,
	output logic        is_end,
	output logic        last
);
	import cscw_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       advance;
	logic       emit_free;
	logic       load;
	burst_t     burst;

	assign advance  = valid_s1 && ((burst.num == 2'd0) || emit_free);
	assign load     = advance && (burst.num != 2'd0);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			char_s1 <= in_char;
	end

	cscw_scan #(
		.COUNT_BITS(COUNT_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.char_s1 (char_s1),
		.burst   (burst)
	);

	cscw_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.burst      (burst),
		.free       (emit_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.out_length (out_length),
		.is_end     (is_end),
		.last       (last)
	);

endmodule

// ----- sim/comment_strip_whitespace_collapse_tb.sv -----
// ----------------------------------------------------------------------------
// comment_strip_whitespace_collapse_tb
// Feeds byte texts through the comment stripper and checks every result,
// field by field, against a cycle-free model of the scanner kept here.
// ----------------------------------------------------------------------------
module comment_strip_whitespace_collapse_tb;
	import cscw_pkg::*;

	localparam int CNT_BITS = 16;
	localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 1;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 190;

	typedef struct packed {
		logic [7:0]  ch;
		logic [15:0] len;
		logic        term;
		logic        fin;
	} text_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_char = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_char;
	logic [15:0] out_length;
	logic        is_end;
	logic        last;

	logic [7:0]   text_bytes[$];
	text_result_t expected_text[$];
	text_result_t burst[$];
	logic [7:0]   blanks[4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

	scan_mode_t       scan_st = MODE_NORMAL;
	logic             nl_pend = 1'b0;
	logic             sp_pend = 1'b0;
	longint unsigned  emit_cnt = 0;

	int unsigned cycle_cnt = 0;
	int          errors = 0;
	int          hold_left = 0;
	int          holds = 0;

	comment_strip_whitespace_collapse #(
		.COUNT_BITS(CNT_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_char(in_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.out_length(out_length),
		.is_end(is_end),
		.last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit take_break();
		return (text_bytes.size() > 140 || text_bytes.size() < 60) &&
			$urandom_range(0, 99) < 20;
	endfunction

	function automatic void emit(logic [7:0] c);
		burst.push_back('{c, 16'd0, 1'b0, 1'b0});
		if (emit_cnt < CNT_MAX)
			emit_cnt++;
	endfunction

	function automatic void emit_separator();
		if (nl_pend) begin
			emit(CH_LF);
			nl_pend = 1'b0;
			sp_pend = 1'b0;
		end
		if (sp_pend) begin
			emit(CH_SPACE);
			sp_pend = 1'b0;
		end
	endfunction

	function automatic void scan_plain(logic [7:0] c);
		if (c == CH_SLASH) begin
			scan_st = MODE_SLASH;
		end else if (c == CH_LF || c == CH_CR) begin
			nl_pend = 1'b1;
		end else if (c == CH_SPACE || c == CH_TAB) begin
			sp_pend = 1'b1;
		end else begin
			emit_separator();
			emit(c);
			scan_st = (c == CH_QUOTE) ? MODE_STRING : MODE_NORMAL;
		end
	endfunction

	function automatic void predict_byte(logic [7:0] c);
		text_result_t r;
		burst.delete();
		if (c == CH_NUL) begin
			if (scan_st == MODE_SLASH) begin
				emit_separator();
				emit(CH_SLASH);
			end
			r.ch = CH_NUL;
			r.len = (emit_cnt > 64'd65535) ? 16'hFFFF : emit_cnt[15:0];
			r.term = 1'b1;
			r.fin = 1'b0;
			burst.push_back(r);
			scan_st = MODE_NORMAL;
			nl_pend = 1'b0;
			sp_pend = 1'b0;
			emit_cnt = 0;
		end else begin
			case (scan_st)
				MODE_SLASH: begin
					if (c == CH_SLASH) begin
						scan_st = MODE_LINE;
					end else if (c == CH_STAR) begin
						scan_st = MODE_STAR;
					end else begin
						emit_separator();
						emit(CH_SLASH);
						scan_st = MODE_NORMAL;
						scan_plain(c);
					end
				end
				MODE_LINE: begin
					if (c == CH_LF) begin
						scan_st = MODE_NORMAL;
						nl_pend = 1'b1;
					end
				end
				MODE_BLOCK: begin
					if (c == CH_STAR)
						scan_st = MODE_STAR;
				end
				MODE_STAR: begin
					if (c == CH_SLASH)
						scan_st = MODE_NORMAL;
					else if (c != CH_STAR)
						scan_st = MODE_BLOCK;
				end
				MODE_STRING: begin
					emit(c);
					if (c == CH_QUOTE)
						scan_st = MODE_NORMAL;
				end
				default: begin
					scan_st = MODE_NORMAL;
					scan_plain(c);
				end
			endcase
		end
		foreach (burst[i]) begin
			r = burst[i];
			r.fin = (i == burst.size() - 1);
			expected_text.push_back(r);
		end
	endfunction

	task automatic queue_str(string s);
		for (int i = 0; i < s.len(); i++)
			text_bytes.push_back(s[i]);
	endtask

	function automatic logic [7:0] word_char();
		logic [7:0] c;
		c = 8'($urandom_range(33, 126));
		if (c == CH_SLASH || c == CH_QUOTE)
			c = "a";
		return c;
	endfunction

	task automatic queue_random_text();
		logic [7:0] c;
		repeat ($urandom_range(1, 10)) begin
			case ($urandom_range(0, 9))
				0, 1, 2: repeat ($urandom_range(1, 6)) text_bytes.push_back(word_char());
				3, 4: repeat ($urandom_range(1, 4))
					text_bytes.push_back(blanks[$urandom_range(0, 3)]);
				5: begin
					queue_str("//");
					repeat ($urandom_range(0, 5)) begin
						c = 8'($urandom_range(1, 255));
						text_bytes.push_back(c == CH_LF ? CH_CR : c);
					end
					text_bytes.push_back(CH_LF);
				end
				6: begin
					queue_str("/*");
					repeat ($urandom_range(0, 5)) begin
						c = 8'($urandom_range(1, 255));
						text_bytes.push_back(c == CH_SLASH ? CH_STAR : c);
					end
					queue_str("*/");
				end
				7: begin
					text_bytes.push_back(CH_QUOTE);
					repeat ($urandom_range(0, 5)) begin
						c = 8'($urandom_range(1, 255));
						text_bytes.push_back(c == CH_QUOTE ? CH_SPACE : c);
					end
					text_bytes.push_back(CH_QUOTE);
				end
				8: begin
					text_bytes.push_back(CH_SLASH);
					text_bytes.push_back(word_char());
				end
				default: text_bytes.push_back(8'($urandom_range(1, 255)));
			endcase
		end
		text_bytes.push_back(CH_NUL);
	endtask

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[comment_strip_whitespace_collapse] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_byte(in_char);
				void'(text_bytes.pop_front());
			end
			if (!(in_valid && in_stall)) begin
				if (text_bytes.size() != 0 && !take_break()) begin
					in_valid <= 1'b1;
					in_char <= text_bytes[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (arst_n && ((holds == 0 && cycle_cnt > 60) ||
				(holds == 1 && text_bytes.size() < 50 && text_bytes.size() > 10))) begin
			hold_left <= 400;
			holds <= holds + 1;
		end
	end

	always @(posedge clk) begin : monitor
		text_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_text.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: char %h len %0d end %b last %b",
						out_char, out_length, is_end, last);
			end else begin
				want = expected_text.pop_front();
				if (out_char !== want.ch || out_length !== want.len ||
						is_end !== want.term || last !== want.fin) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch (expected/actual): char %h/%h len %0d/%0d ",
							"end %b/%b last %b/%b"}, want.ch, out_char, want.len,
							out_length, want.term, is_end, want.fin, last);
				end
			end
		end
		out_stall <= (hold_left != 0) || take_break();
	end

	initial begin
		int base;
		queue_str(" /x\n\t//\015\n/*/\377");
		text_bytes.push_back(CH_NUL);
		queue_str("\"/\"/**/ /");
		text_bytes.push_back(CH_NUL);
		queue_str("\001\"x");
		text_bytes.push_back(CH_NUL);
		queue_str("\200 /*");
		text_bytes.push_back(CH_NUL);
		text_bytes.push_back(CH_NUL);
		base = text_bytes.size();
		while (text_bytes.size() < base + RANDOM_ITEMS)
			queue_random_text();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk);
		while (text_bytes.size() != 0 || in_valid || expected_text.size() != 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[comment_strip_whitespace_collapse] OK");
		else
			$display("[comment_strip_whitespace_collapse] ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cscw_pkg.sv
rtl/cscw_scan.sv
rtl/cscw_emit.sv
rtl/comment_strip_whitespace_collapse.sv
sim/comment_strip_whitespace_collapse_tb.sv
